/* hdl/olbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olbs_pkg: shared types and constants for the single-pin backlight link master
// Word layouts, configuration register indexes, sequencer phases and CRC-8.
// ----------------------------------------------------------------------------
package olbs_pkg;

	localparam logic [7:0] CRC_INIT   = 8'hAC;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] REQ_FLAG   = 8'h80;
	localparam logic [6:0] BRIGHT_MAX = 7'd127;

	localparam logic [5:0] PREAMBLE_RESET = 6'd60;
	localparam logic [1:0] ATTEMPTS_RESET = 2'd3;

	localparam logic [5:0] LOW_TICKS   = 6'd2;
	localparam logic [5:0] TX_BITS     = 6'd16;
	localparam logic [5:0] RX_BITS     = 6'd32;
	localparam logic [5:0] RX_CRC_BITS = 6'd24;

	localparam int CFG_DATA_W = 6;

	// request kinds carried in req_type
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef enum logic [0:0] {
		CFG_PREAMBLE = 1'b0,
		CFG_ATTEMPTS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [5:0] preamble_ticks;
		logic [1:0] max_attempts;
	} cfg_t;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_PRE  = 7'b0000010,
		PH_LOW  = 7'b0000100,
		PH_TX   = 7'b0001000,
		PH_TAIL = 7'b0010000,
		PH_GAP  = 7'b0100000,
		PH_RX   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] brightness;
		logic       line_in;
	} in_word_t;

	typedef struct packed {
		logic        line_level;
		logic        line_drive;
		logic        busy_res;
		logic        done_res;
		logic        success;
		logic [23:0] response_data;
	} out_word_t;

	// One MSB-first CRC-8 step: shift, fold the old top bit and the data bit.
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic d);
		return {crc[6:0], 1'b0} ^ ((crc[7] ^ d) ? CRC_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] crc_byte(input logic [7:0] b);
		logic [7:0] crc;
		crc = CRC_INIT;
		for (int i = 7; i >= 0; i--) begin
			crc = crc_step(crc, b[i]);
		end
		return crc;
	endfunction

endpackage

/* hdl/olbs_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olbs_engine: session sequencer
// Holds the link state, advances it by one word when stepped and presents the
// result word for that step.
// ----------------------------------------------------------------------------
module olbs_engine
	import olbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  item,
	input  cfg_t      cfg,
	output out_word_t result
);

	phase_t      phase_q, phase_n;
	logic [5:0]  tick_q, tick_n;
	logic [5:0]  bit_q, bit_n;
	logic [15:0] tx_q, tx_n;
	logic [15:0] tx_load_q, tx_load_n;
	logic [31:0] rx_q, rx_n;
	logic [7:0]  crc_q, crc_n;
	logic [1:0]  att_q, att_n;

	always_comb begin
		logic [7:0] req;
		logic [5:0] tick_inc;
		logic [5:0] bit_inc;
		logic       pass;
		logic       last_try;

		phase_n   = phase_q;
		tick_n    = tick_q;
		bit_n     = bit_q;
		tx_n      = tx_q;
		tx_load_n = tx_load_q;
		rx_n      = rx_q;
		crc_n     = crc_q;
		att_n     = att_q;
		result    = '0;

		req      = {1'b1, item.brightness[7] ? BRIGHT_MAX : item.brightness[6:0]} | REQ_FLAG;
		tick_inc = tick_q + 6'd1;
		bit_inc  = bit_q + 6'd1;
		pass     = (crc_q == rx_q[7:0]);
		last_try = ({1'b0, att_q} + 3'd1) >= {1'b0, cfg.max_attempts};

		if (!item.req_type) begin
			if (phase_q == PH_IDLE) begin
				tx_load_n = {req, crc_byte(req)};
				tx_n      = {req, crc_byte(req)};
				att_n     = 2'd0;
				phase_n   = PH_PRE;
				tick_n    = 6'd0;
				bit_n     = 6'd0;
				rx_n      = 32'd0;
				crc_n     = CRC_INIT;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_PRE: begin
					tick_n = tick_inc;
					if (tick_inc >= cfg.preamble_ticks) begin
						phase_n = PH_LOW;
						tick_n  = 6'd0;
					end
				end
				PH_LOW: begin
					tick_n = tick_inc;
					if (tick_inc >= LOW_TICKS) begin
						phase_n = PH_TX;
						tick_n  = 6'd0;
						bit_n   = 6'd0;
					end
				end
				PH_TX: begin
					bit_n = bit_inc;
					if (bit_inc >= TX_BITS) begin
						phase_n = PH_TAIL;
					end else begin
						tx_n = {tx_q[14:0], 1'b0};
					end
				end
				PH_TAIL: begin
					phase_n = PH_GAP;
				end
				PH_GAP: begin
					rx_n    = {rx_q[30:0], item.line_in};
					crc_n   = crc_step(crc_q, item.line_in);
					bit_n   = 6'd1;
					phase_n = PH_RX;
				end
				PH_RX: begin
					if (bit_q < RX_BITS) begin
						rx_n  = {rx_q[30:0], item.line_in};
						bit_n = bit_inc;
						// the check covers only the first 24 samples
						if (bit_q < RX_CRC_BITS) begin
							crc_n = crc_step(crc_q, item.line_in);
						end
					end else if (pass || last_try) begin
						result.done_res = 1'b1;
						result.success  = pass;
						phase_n         = PH_IDLE;
						tick_n          = 6'd0;
						bit_n           = 6'd0;
					end else begin
						att_n   = att_q + 2'd1;
						phase_n = PH_PRE;
						tick_n  = 6'd0;
						bit_n   = 6'd0;
						rx_n    = 32'd0;
						crc_n   = CRC_INIT;
						tx_n    = tx_load_q;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end

		case (phase_n)
			PH_LOW: begin
				result.line_level = 1'b0;
				result.line_drive = 1'b1;
			end
			PH_TX, PH_TAIL: begin
				result.line_level = tx_n[15];
				result.line_drive = 1'b1;
			end
			PH_GAP, PH_RX: begin
				result.line_level = 1'b0;
				result.line_drive = 1'b0;
			end
			default: begin
				result.line_level = 1'b1;
				result.line_drive = 1'b1;
			end
		endcase
		result.busy_res      = (phase_n != PH_IDLE);
		result.response_data = rx_n[31:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= 6'd0;
			bit_q     <= 6'd0;
			tx_q      <= 16'd0;
			tx_load_q <= 16'd0;
			rx_q      <= 32'd0;
			crc_q     <= CRC_INIT;
			att_q     <= 2'd0;
		end else if (step) begin
			phase_q   <= phase_n;
			tick_q    <= tick_n;
			bit_q     <= bit_n;
			tx_q      <= tx_n;
			tx_load_q <= tx_load_n;
			rx_q      <= rx_n;
			crc_q     <= crc_n;
			att_q     <= att_n;
		end
	end

endmodule

/* hdl/one_wire_backlight_session.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_backlight_session: single-pin backlight link master with CRC-8
// Start and tick words drive a session sequencer; every word yields one
// result word.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_data  (in_word_t)
//  out      output     out_valid / out_ready  out_data (out_word_t)
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle unless the result side stalls: the sequencer updates
// at acceptance and the result is registered, so it appears the cycle after
// the word is taken. The result register frees in_ready when empty or drained.
// Reset leaves the link idle (pin driven high), 60 preamble ticks, 3 attempts.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module one_wire_backlight_session
	import olbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	out_word_t result;
	out_word_t out_q;
	logic      out_valid_q;
	logic      take;

	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_ticks <= PREAMBLE_RESET;
			cfg_q.max_attempts   <= ATTEMPTS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PREAMBLE: cfg_q.preamble_ticks <= cfg_data[5:0];
				CFG_ATTEMPTS: cfg_q.max_attempts   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	olbs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (take),
		.item   (in_data),
		.cfg    (cfg_q),
		.result (result)
	);

	// hold the result until drained, refill on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= result;
		end
	end

endmodule

/* hdl/olbs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olbs_checker: port-level checks for the backlight link master
// Watches the handshakes and result words seen at the top level.
// ----------------------------------------------------------------------------
module olbs_checker
	import olbs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted word gave no result");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result word dropped or changed");

	a_success_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.success) |-> out_data.done_res)
		else $error("success flagged outside a done word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.done_res) |-> (!out_data.busy_res && out_data.line_drive))
		else $error("done word while still busy or pin released");

	a_released_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.line_drive) |-> (!out_data.line_level && out_data.busy_res))
		else $error("released pin with level high or while idle");

endmodule

bind one_wire_backlight_session olbs_checker u_olbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* tb/sv/backlight_session_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backlight_session_checker: prediction and checking for the backlight link
// Watches the input, result and register channels. Each accepted input word
// steps a local copy of the session sequencer, and the predicted result word
// is queued. Each accepted result word is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module backlight_session_checker
	import olbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_word_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_word_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	logic [5:0]  pre_ticks;
	logic [1:0]  attempts;
	phase_t      ph;
	logic [5:0]  tick_n;
	logic [5:0]  bit_n;
	logic [15:0] tx_word;
	logic [31:0] rx_word;
	logic [1:0]  tries;
	logic [7:0]  req_byte;

	out_word_t predicted_words[$];
	out_word_t want;

	function automatic logic [7:0] crc_msb_first(input logic [31:0] v, input int n);
		logic [7:0] crc;
		logic       msb;
		crc = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			msb = crc[7];
			crc = {crc[6:0], 1'b0};
			if (msb)
				crc = crc ^ CRC_POLY;
			if (v[31])
				crc = crc ^ CRC_POLY;
			v = v << 1;
		end
		return crc;
	endfunction

	function automatic void open_session();
		ph      = PH_PRE;
		tick_n  = '0;
		bit_n   = '0;
		rx_word = '0;
		tx_word = {req_byte, crc_msb_first({req_byte, 24'h0}, 8)};
	endfunction

	function automatic out_word_t advance_link(input in_word_t w);
		out_word_t r;
		logic      done;
		logic      ok;
		done = 1'b0;
		ok   = 1'b0;
		if (w.req_type != REQ_TICK) begin
			// a start while busy is dropped
			if (ph == PH_IDLE) begin
				req_byte = REQ_FLAG |
					((w.brightness > BRIGHT_MAX) ? BRIGHT_MAX : w.brightness[6:0]);
				tries = '0;
				open_session();
			end
		end else begin
			case (ph)
				PH_PRE: begin
					tick_n = tick_n + 6'd1;
					if (tick_n >= pre_ticks) begin
						ph     = PH_LOW;
						tick_n = '0;
					end
				end
				PH_LOW: begin
					tick_n = tick_n + 6'd1;
					if (tick_n >= LOW_TICKS) begin
						ph     = PH_TX;
						tick_n = '0;
						bit_n  = '0;
					end
				end
				PH_TX: begin
					bit_n = bit_n + 6'd1;
					if (bit_n >= TX_BITS)
						ph = PH_TAIL;
					else
						tx_word = tx_word << 1;
				end
				PH_TAIL: ph = PH_GAP;
				PH_GAP: begin
					// the tick ending the released slot takes the first sample
					rx_word = {rx_word[30:0], w.line_in};
					bit_n   = 6'd1;
					ph      = PH_RX;
				end
				PH_RX: begin
					if (bit_n < RX_BITS) begin
						rx_word = {rx_word[30:0], w.line_in};
						bit_n   = bit_n + 6'd1;
					end else begin
						if (crc_msb_first(rx_word, RX_CRC_BITS) == rx_word[7:0]) begin
							done = 1'b1;
							ok   = 1'b1;
							ph   = PH_IDLE;
						end else if (int'(tries) + 1 >= int'(attempts)) begin
							done = 1'b1;
							ph   = PH_IDLE;
						end else begin
							// retry straight into the next preamble
							tries = tries + 2'd1;
							open_session();
						end
						if (ph == PH_IDLE) begin
							tick_n = '0;
							bit_n  = '0;
						end
					end
				end
				default: ph = PH_IDLE;
			endcase
		end

		r               = '0;
		r.busy_res      = (ph != PH_IDLE);
		r.done_res      = done;
		r.success       = ok;
		r.response_data = rx_word[31:8];
		case (ph)
			PH_LOW: begin
				r.line_level = 1'b0;
				r.line_drive = 1'b1;
			end
			PH_TX, PH_TAIL: begin
				r.line_level = tx_word[15];
				r.line_drive = 1'b1;
			end
			PH_GAP, PH_RX: begin
				r.line_level = 1'b0;
				r.line_drive = 1'b0;
			end
			default: begin
				r.line_level = 1'b1;
				r.line_drive = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [23:0] exp_v,
		input logic [23:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_ticks = PREAMBLE_RESET;
			attempts  = ATTEMPTS_RESET;
			ph        = PH_IDLE;
			tick_n    = '0;
			bit_n     = '0;
			tx_word   = '0;
			rx_word   = '0;
			tries     = '0;
			req_byte  = '0;
			predicted_words.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_words.size() == 0) begin
					$error("result word with no prediction waiting");
					fail_count++;
				end else begin
					want = predicted_words.pop_front();
					compare_field("line_level", 24'(want.line_level),
						24'(out_data.line_level));
					compare_field("line_drive", 24'(want.line_drive),
						24'(out_data.line_drive));
					compare_field("busy_res", 24'(want.busy_res), 24'(out_data.busy_res));
					compare_field("done_res", 24'(want.done_res), 24'(out_data.done_res));
					compare_field("success", 24'(want.success), 24'(out_data.success));
					compare_field("response_data", want.response_data,
						out_data.response_data);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PREAMBLE)
					pre_ticks = cfg_data[5:0];
				else
					attempts = cfg_data[1:0];
			end
			if (in_valid && in_ready)
				predicted_words.push_back(advance_link(in_data));
			pending = predicted_words.size();
		end
	end

endmodule

/* tb/sv/one_wire_backlight_session_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_backlight_session_test: stimulus and verdict for the link master
// Drives start and tick words with random gaps, shapes whole sessions with
// well-formed, corrupted and random response words, changes the preamble
// and attempt registers between requests, and stalls the result side at random.
// ----------------------------------------------------------------------------
module one_wire_backlight_session_test;
	import olbs_pkg::*;

	localparam int   RANDOM_WORDS   = 1850;
	localparam int   WATCHDOG_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_word_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int words_sent    = 0;
	int results_taken = 0;
	int stall_left    = 0;
	bit quiet_tx      = 1'b0;
	bit quiet_rx      = 1'b0;
	bit link_busy     = 1'b0;
	int pre_cfg       = PREAMBLE_RESET;
	int att_cfg       = ATTEMPTS_RESET;

	one_wire_backlight_session dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	backlight_session_checker link_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_cycles(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] good_reply(input logic [23:0] payload);
		logic [7:0] crc;
		crc = CRC_INIT;
		for (int i = 23; i >= 0; i--)
			crc = crc_step(crc, payload[i]);
		return {payload, crc};
	endfunction

	task automatic offer_word(input logic kind, input logic [7:0] level, input logic pin);
		int g;
		g = gap_cycles(quiet_tx);
		@(negedge clk);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_data  <= {kind, level, pin};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_PREAMBLE)
			pre_cfg = val;
		else
			att_cfg = val[1:0];
	endtask

	// Hold the sender until every result is in and the link has gone idle.
	task automatic settle();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// flush a sequence knocked out of step by stray words
		while (link_busy && guard < 400) begin
			offer_word(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			@(negedge clk);
			in_valid <= 1'b0;
			while (pending != 0) @(negedge clk);
			guard++;
		end
	endtask

	// One session's ticks; the response word is laid on the sampling ticks.
	task automatic run_session(input logic [31:0] reply, input int noise_pct);
		int span;
		int first;
		span  = (pre_cfg == 0) ? 1 : pre_cfg;
		first = span + 20;
		for (int k = 1; k <= span + 52; k++) begin
			if ($urandom_range(1, 100) <= noise_pct)
				offer_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			if (k >= first && k < first + 32)
				offer_word(REQ_TICK, 8'($urandom_range(0, 255)), reply[31 - (k - first)]);
			else
				offer_word(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_request(input logic [7:0] level, input int good_at, input bit restart,
		input int noise_pct);
		int sessions;
		int s;
		bit passed;
		sessions = (att_cfg == 0) ? 1 : att_cfg;
		s        = 0;
		passed   = 1'b0;
		offer_word(REQ_START, level, 1'($urandom_range(0, 1)));
		if (restart)
			offer_word(REQ_START, ~level, 1'b0);
		while (s < sessions && !passed) begin
			if (s == good_at) begin
				run_session(good_reply(24'($urandom_range(0, 24'hFFFFFF))), noise_pct);
				passed = 1'b1;
			end else if ($urandom_range(0, 1)) begin
				run_session(good_reply(24'($urandom_range(0, 24'hFFFFFF))) ^
					(32'h1 << $urandom_range(0, 31)), noise_pct);
			end else begin
				run_session($urandom, noise_pct);
			end
			s++;
		end
	endtask

	// Result side: random stalls, one long hold-off part way through.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			results_taken++;
			link_busy = out_data.busy_res;
			if (results_taken % 64 == 0)
				quiet_rx = ($urandom_range(0, 2) == 0);
			if (results_taken == 500)
				stall_left = 300;
			else
				stall_left = gap_cycles(quiet_rx);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		int r;
		int pre;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PREAMBLE;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ticks while idle, then a default-setting request with a clamped level
		offer_word(REQ_TICK, 8'h00, 1'b0);
		offer_word(REQ_TICK, 8'hFF, 1'b1);
		run_request(8'hFF, 0, 1'b0, 0);

		// zero preamble and zero attempts; a second start while busy is dropped
		settle();
		write_reg(CFG_PREAMBLE, 6'd0);
		write_reg(CFG_ATTEMPTS, 6'd0);
		run_request(8'h00, 3, 1'b1, 0);

		// shortest preamble, two retries before a good response
		settle();
		write_reg(CFG_PREAMBLE, 6'd1);
		write_reg(CFG_ATTEMPTS, 6'd3);
		run_request(8'h80, 2, 1'b0, 0);

		// longest preamble, single attempt that fails
		settle();
		write_reg(CFG_PREAMBLE, 6'd63);
		write_reg(CFG_ATTEMPTS, 6'd1);
		run_request(8'h7F, 3, 1'b0, 0);

		while (words_sent < RANDOM_WORDS) begin
			settle();
			r = $urandom_range(0, 99);
			if (r < 70)
				pre = $urandom_range(0, 6);
			else if (r < 90)
				pre = $urandom_range(7, 20);
			else
				pre = $urandom_range(50, 63);
			write_reg(CFG_PREAMBLE, 6'(pre));
			write_reg(CFG_ATTEMPTS, 6'($urandom_range(0, 3)));
			repeat ((pre > 20) ? 1 : $urandom_range(2, 5)) begin
				quiet_tx = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						offer_word(REQ_TICK, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
				run_request(8'($urandom_range(0, 255)), $urandom_range(0, 3),
					$urandom_range(0, 9) == 0, ($urandom_range(0, 3) == 0) ? 4 : 0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
